// ----- rtl/itkl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itkl_pkg
// Shared types and constants of the implicit tree key lookup block.
// ----------------------------------------------------------------------------
package itkl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int KEY_BITS    = 16;
  localparam int VAL_W       = 16;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int SLOT_W      = 9;
  localparam int CNT_W       = 9;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int ENTRY_W     = KEY_BITS + VAL_W;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FWD_COUNT = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REV_COUNT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FWD_MISS  = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_REV_MISS  = 2'd3;

  typedef enum logic [1:0] {
    REQ_LOAD_FWD = 2'd0,
    REQ_LOAD_REV = 2'd1,
    REQ_LOOK_FWD = 2'd2,
    REQ_LOOK_REV = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_RESP
  } walk_state_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [SLOT_W-1:0]   slot_index;
    logic [15:0]         key;
    logic [VAL_W-1:0]    entry_value;
  } itkl_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] fwd_limit;
    logic [SLOT_W-1:0] rev_limit;
    logic [VAL_W-1:0]  fwd_miss;
    logic [VAL_W-1:0]  rev_miss;
  } itkl_cfg_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] value;
  } itkl_res_t;

endpackage : itkl_pkg
`default_nettype wire

// ----- rtl/itkl_walk.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// itkl_walk
// Table memory for both trees plus the sequencer that loads slots and walks
// a tree one level per cycle.
// ----------------------------------------------------------------------------
module itkl_walk
  import itkl_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      req_valid,
  input  wire itkl_req_t req,
  output logic           req_ready,
  input  wire itkl_cfg_t cfg,
  output logic           res_valid,
  output itkl_res_t      res,
  input  wire logic      res_ready
);

  // Upper address bit selects the tree: 0 forward, 1 reverse
  logic [ENTRY_W-1:0] tree_mem [0:2*TABLE_DEPTH-1];
  logic [ENTRY_W-1:0] rd_q_r;

  walk_state_t         state_r, state_nxt;
  logic                tbl_r, tbl_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [SLOT_W-1:0]   limit_r, limit_nxt;
  logic [KEY_BITS-1:0] want_r, want_nxt;
  logic                res_found_r, res_found_nxt;
  logic [VAL_W-1:0]    res_value_r, res_value_nxt;

  logic                rd_en, wr_en;
  logic [ADDR_W:0]     rd_addr, wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic                accept, is_lookup, req_tbl, slot_ok;
  logic [SLOT_W-1:0]   req_limit;
  logic [SLOT_W-1:0]   req_slot_m1;
  logic [KEY_BITS-1:0] have_key;
  logic [VAL_W-1:0]    have_val;
  logic                hit, go_on;
  logic [SLOT_W:0]     child, child_m1;

  assign req_ready = (state_r == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign is_lookup = (req.req_type == REQ_LOOK_FWD) || (req.req_type == REQ_LOOK_REV);
  assign req_tbl   = (req.req_type == REQ_LOAD_REV) || (req.req_type == REQ_LOOK_REV);
  assign req_limit = req_tbl ? cfg.rev_limit : cfg.fwd_limit;
  assign slot_ok   = (req.slot_index != '0) &&
                     (req.slot_index <= SLOT_W'(TABLE_DEPTH));
  assign req_slot_m1 = req.slot_index - SLOT_W'(1);

  assign have_key = rd_q_r[ENTRY_W-1:VAL_W];
  assign have_val = rd_q_r[VAL_W-1:0];
  assign hit      = (have_key == want_r);
  // Smaller stored key: go right (2i+1), else left (2i)
  assign child    = {slot_r, (have_key < want_r)};
  assign child_m1 = child - (SLOT_W+1)'(1);
  assign go_on    = !hit && (child <= {1'b0, limit_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && is_lookup) begin
          state_nxt = (req_limit == '0) ? ST_RESP : ST_WALK;
        end
      end
      ST_WALK: begin
        if (!go_on) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Memory access and walk datapath
  always_comb begin
    tbl_nxt       = tbl_r;
    slot_nxt      = slot_r;
    limit_nxt     = limit_r;
    want_nxt      = want_r;
    res_found_nxt = res_found_r;
    res_value_nxt = res_value_r;
    rd_en         = 1'b0;
    rd_addr       = {tbl_r, child_m1[ADDR_W-1:0]};
    wr_en         = 1'b0;
    wr_addr       = {req_tbl, req_slot_m1[ADDR_W-1:0]};
    wr_data       = {req.key[KEY_BITS-1:0], req.entry_value};
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (is_lookup) begin
            // Preload the miss answer; a hit overwrites it
            tbl_nxt       = req_tbl;
            slot_nxt      = SLOT_W'(1);
            limit_nxt     = req_limit;
            want_nxt      = req.key[KEY_BITS-1:0];
            res_found_nxt = 1'b0;
            res_value_nxt = req_tbl ? cfg.rev_miss : cfg.fwd_miss;
            rd_en         = 1'b1;
            rd_addr       = {req_tbl, ADDR_W'(0)};
          end else begin
            wr_en = slot_ok;
          end
        end
      end
      ST_WALK: begin
        if (hit) begin
          res_found_nxt = 1'b1;
          res_value_nxt = have_val;
        end else if (go_on) begin
          slot_nxt = child[SLOT_W-1:0];
          rd_en    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign res_valid = (state_r == ST_RESP);
  assign res.found = res_found_r;
  assign res.value = res_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tbl_r       <= tbl_nxt;
    slot_r      <= slot_nxt;
    limit_r     <= limit_nxt;
    want_r      <= want_nxt;
    res_found_r <= res_found_nxt;
    res_value_r <= res_value_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tree_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= tree_mem[rd_addr];
    end
  end

endmodule : itkl_walk
`default_nettype wire

// ----- rtl/implicit_tree_key_lookup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// implicit_tree_key_lookup
// Forward and reverse key-to-value tables searched as implicit binary trees.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load transfer writes its slot and gives no
// result. A lookup reads the root, then one tree level per read until it hits
// or passes the entry count: the walk reads one slot of the shared table
// memory per cycle, and that single read port sets the pace. The answer then
// waits in an output register, so the next item is taken while it is still
// unclaimed. Entry counts above the depth act as the full depth. Configuration
// must be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module implicit_tree_key_lookup
  import itkl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // in_tdata: slot_index[8:0], key[24:9], entry_value[40:25], zero fill
  input  wire logic [47:0]           in_tdata,
  // in_tuser: req_type[1:0]
  input  wire logic [1:0]            in_tuser,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // out_tdata: result_value[15:0]
  output logic [15:0]                out_tdata,
  // out_tuser: found[0]
  output logic                       out_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic [CNT_W-1:0] fwd_count_r, rev_count_r;
  logic [VAL_W-1:0] fwd_miss_r, rev_miss_r;

  itkl_req_t req;
  itkl_cfg_t cfg;
  itkl_res_t res;
  logic      res_valid, res_ready;

  logic             out_valid_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_count_r <= '0;
      rev_count_r <= '0;
      fwd_miss_r  <= '1;
      rev_miss_r  <= '1;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FWD_COUNT: fwd_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_REV_COUNT: rev_count_r <= cfg_wdata[CNT_W-1:0];
        CFG_FWD_MISS:  fwd_miss_r  <= cfg_wdata[VAL_W-1:0];
        CFG_REV_MISS:  rev_miss_r  <= cfg_wdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp counts to the table depth
  assign cfg.fwd_limit = (fwd_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : fwd_count_r;
  assign cfg.rev_limit = (rev_count_r > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : rev_count_r;
  assign cfg.fwd_miss  = fwd_miss_r;
  assign cfg.rev_miss  = rev_miss_r;

  assign req.req_type    = req_type_t'(in_tuser);
  assign req.slot_index  = in_tdata[8:0];
  assign req.key         = in_tdata[24:9];
  assign req.entry_value = in_tdata[40:25];

  itkl_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_tvalid),
    .req       (req),
    .req_ready (in_tready),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: refill when empty or when the held result transfers
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_found_r <= res.found;
      out_value_r <= res.value;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_value_r;

endmodule : implicit_tree_key_lookup
`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the implicit tree key lookup block.
// A short table of directed transfers covers empty tables, the key extremes,
// ignored loads and the miss codes. Random phases follow: each one writes new
// settings, loads both tables as valid implicit search trees and then mixes
// lookups with overwrites and stray loads. A local tree walk predicts each
// answer not fixed by a directed row; both stream sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import itkl_pkg::*;

  typedef struct packed {
    logic        hit;
    logic [15:0] ans;
  } answer_t;

  typedef struct packed {
    req_type_t   req;
    logic [8:0]  slot;
    logic [15:0] key;
    logic [15:0] val;
    logic        typed;
    logic        hit;
    logic [15:0] ans;
  } step_t;

  localparam int DIR_ROWS        = 22;
  localparam int DIR_EMPTY_ROWS  = 2;
  localparam int DRAIN_CYCLES    = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic        cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // mirror of both tables and of the settings; side 0 forward, side 1 reverse
  logic [15:0] slot_key [2][1:TABLE_DEPTH];
  logic [15:0] slot_val [2][1:TABLE_DEPTH];
  logic [15:0] plan_key [2][1:TABLE_DEPTH];
  logic [8:0]  entry_limit [2];
  logic [15:0] miss_code [2];

  logic [15:0] sorted_keys [0:TABLE_DEPTH-1];
  int          inorder_next;

  answer_t     answers_due [$];
  step_t       steps [DIR_ROWS];

  bit          idling = 1'b0;
  int          stall_left = 0;
  int          error_count = 0;
  int          lookups_sent = 0;
  int          hits_due = 0;
  int          loads_sent = 0;
  int          settings_written = 0;

  implicit_tree_key_lookup uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  task automatic note_error(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  // slots a walk may visit: the count, saturated at the depth
  function automatic int reach(input bit side);
    return (entry_limit[side] > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_limit[side]);
  endfunction

  function automatic void tree_search(input bit side, input logic [15:0] want,
                                      output logic hit, output logic [15:0] ans);
    int lim;
    int s;
    lim = reach(side);
    s   = 1;
    hit = 1'b0;
    ans = miss_code[side];
    while (s <= lim) begin
      if (slot_key[side][s] == want) begin
        hit = 1'b1;
        ans = slot_val[side][s];
        break;
      end
      s = (slot_key[side][s] < want) ? 2 * s + 1 : 2 * s;
    end
  endfunction

  // result channel: random stall bursts, checked at the rising edge
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    answer_t due;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready) begin
      if (answers_due.size() == 0) begin
        note_error($sformatf("unexpected result found=%b value=%h", out_tuser, out_tdata));
      end else begin
        due = answers_due.pop_front();
        if (out_tuser !== due.hit)
          note_error($sformatf("found %b, want %b", out_tuser, due.hit));
        if (out_tdata !== due.ans)
          note_error($sformatf("value %h, want %h", out_tdata, due.ans));
      end
    end
  end

  task automatic issue_request(input req_type_t req, input logic [8:0] slot,
                               input logic [15:0] key, input logic [15:0] val,
                               input bit typed, input logic t_hit,
                               input logic [15:0] t_ans);
    bit          side;
    logic        hit;
    logic [15:0] ans;
    side = req[0];
    @(negedge clk);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {7'd0, val, key, slot};
    do @(posedge clk); while (!in_tready);
    // transfer taken: update the mirror or queue the answer
    if (req == REQ_LOAD_FWD || req == REQ_LOAD_REV) begin
      loads_sent++;
      if (slot >= 1 && slot <= TABLE_DEPTH) begin
        slot_key[side][slot] = key;
        slot_val[side][slot] = val;
      end
    end else begin
      tree_search(side, key, hit, ans);
      if (typed) begin
        hit = t_hit;
        ans = t_ans;
      end
      lookups_sent++;
      if (hit) hits_due++;
      answers_due.push_back('{hit, ans});
    end
  endtask

  // drop valid, wait for every answer, then let the walk finish
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    case (addr)
      CFG_FWD_COUNT: entry_limit[0] = data[8:0];
      CFG_REV_COUNT: entry_limit[1] = data[8:0];
      CFG_FWD_MISS:  miss_code[0]   = data;
      default:       miss_code[1]   = data;
    endcase
  endtask

  task automatic write_settings(input logic [15:0] fc, input logic [15:0] rc,
                                input logic [15:0] fm, input logic [15:0] rm);
    cfg_put(CFG_FWD_COUNT, fc);
    cfg_put(CFG_REV_COUNT, rc);
    cfg_put(CFG_FWD_MISS, fm);
    cfg_put(CFG_REV_MISS, rm);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_written++;
  endtask

  function automatic void place_inorder(input bit side, input int slot, input int n);
    if (slot > n) return;
    place_inorder(side, 2 * slot, n);
    plan_key[side][slot] = sorted_keys[inorder_next];
    inorder_next++;
    place_inorder(side, 2 * slot + 1, n);
  endfunction

  // sorted distinct keys laid out in search-tree order
  function automatic void plan_tree(input bit side, input int n);
    int gap_max;
    int k;
    if (n == 0) return;
    gap_max = 65535 / (n + 1);
    k = $urandom_range(0, gap_max - 1);
    for (int j = 0; j < n; j++) begin
      sorted_keys[j] = k[15:0];
      k += $urandom_range(1, gap_max);
    end
    inorder_next = 0;
    place_inorder(side, 1, n);
  endfunction

  task automatic fill_trees(input int nf, input int nr);
    plan_tree(1'b0, nf);
    plan_tree(1'b1, nr);
    for (int s = 1; s <= ((nf > nr) ? nf : nr); s++) begin
      if (s <= nf)
        issue_request(REQ_LOAD_FWD, s[8:0], plan_key[0][s], 16'($urandom), 0, 0, 0);
      if (s <= nr)
        issue_request(REQ_LOAD_REV, s[8:0], plan_key[1][s], 16'($urandom), 0, 0, 0);
    end
  endtask

  task automatic random_item();
    bit          side;
    int          lim;
    int          pick;
    int          slot;
    logic [15:0] key;
    side = $urandom_range(0, 1);
    lim  = reach(side);
    pick = $urandom_range(0, 99);
    key  = 16'($urandom);
    if (pick < 15) begin
      if ($urandom_range(0, 4) == 0)
        slot = $urandom_range(0, 1) ? 0 : $urandom_range(TABLE_DEPTH + 1, 511);
      else
        slot = $urandom_range(1, TABLE_DEPTH);
      // keep the tree valid half the time: new value under the same key
      if (slot >= 1 && slot <= lim && $urandom_range(0, 1) == 1)
        key = slot_key[side][slot];
      issue_request(side ? REQ_LOAD_REV : REQ_LOAD_FWD, slot[8:0], key,
                    16'($urandom), 0, 0, 0);
    end else begin
      pick = $urandom_range(0, 99);
      if (lim > 0 && pick < 65)
        key = slot_key[side][$urandom_range(1, lim)];
      else if (lim > 0 && pick < 75)
        key = slot_key[side][$urandom_range(1, lim)] + ($urandom_range(0, 1) ? 16'd1 : 16'hFFFF);
      issue_request(side ? REQ_LOOK_REV : REQ_LOOK_FWD, 9'($urandom), key,
                    16'($urandom), 0, 0, 0);
    end
  endtask

  task automatic run_phase(input logic [15:0] fc, input logic [15:0] rc,
                           input logic [15:0] fm, input logic [15:0] rm,
                           input int items, input bit with_idle);
    settle();
    idling = with_idle;
    write_settings(fc, rc, fm, rm);
    fill_trees(reach(0), reach(1));
    repeat (items) random_item();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = REQ_LOAD_FWD;
    in_tdata  = '0;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_FWD_COUNT;
    cfg_wdata = '0;
    entry_limit[0] = '0;
    entry_limit[1] = '0;
    miss_code[0]   = 16'hFFFF;
    miss_code[1]   = 16'hFFFF;

    // the first two rows run on the reset settings, both tables empty
    steps[0]  = '{REQ_LOOK_FWD, 9'd0,   16'h0000, 16'h0000, 1'b1, 1'b0, 16'hFFFF};
    steps[1]  = '{REQ_LOOK_REV, 9'h1FF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'hFFFF};
    steps[2]  = '{REQ_LOAD_FWD, 9'd1,   16'h8000, 16'h1111, 1'b0, 1'b0, 16'h0000};
    steps[3]  = '{REQ_LOAD_FWD, 9'd2,   16'h0000, 16'h2222, 1'b0, 1'b0, 16'h0000};
    steps[4]  = '{REQ_LOAD_FWD, 9'd3,   16'hFFFF, 16'h3333, 1'b0, 1'b0, 16'h0000};
    steps[5]  = '{REQ_LOAD_REV, 9'd1,   16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000};
    steps[6]  = '{REQ_LOOK_FWD, 9'd0,   16'h8000, 16'h0000, 1'b1, 1'b1, 16'h1111};
    steps[7]  = '{REQ_LOOK_FWD, 9'd5,   16'h0000, 16'hFFFF, 1'b1, 1'b1, 16'h2222};
    steps[8]  = '{REQ_LOOK_FWD, 9'd0,   16'hFFFF, 16'h0000, 1'b1, 1'b1, 16'h3333};
    steps[9]  = '{REQ_LOOK_FWD, 9'd0,   16'h4000, 16'h0000, 1'b1, 1'b0, 16'h0000};
    steps[10] = '{REQ_LOOK_REV, 9'd0,   16'h7FFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF};
    steps[11] = '{REQ_LOOK_REV, 9'd0,   16'h8000, 16'h0000, 1'b1, 1'b0, 16'hA5A5};
    // out-of-range slots must leave the tables alone
    steps[12] = '{REQ_LOAD_FWD, 9'd0,   16'h8000, 16'h9999, 1'b0, 1'b0, 16'h0000};
    steps[13] = '{REQ_LOAD_FWD, 9'd257, 16'h8000, 16'hBBBB, 1'b0, 1'b0, 16'h0000};
    steps[14] = '{REQ_LOAD_REV, 9'h1FF, 16'h7FFF, 16'h0000, 1'b0, 1'b0, 16'h0000};
    steps[15] = '{REQ_LOOK_FWD, 9'd0,   16'h8000, 16'h0000, 1'b1, 1'b1, 16'h1111};
    steps[16] = '{REQ_LOOK_REV, 9'd0,   16'h7FFF, 16'h0000, 1'b1, 1'b1, 16'hFFFF};
    steps[17] = '{REQ_LOAD_FWD, 9'd256, 16'h1234, 16'h5678, 1'b0, 1'b0, 16'h0000};
    steps[18] = '{REQ_LOOK_FWD, 9'd0,   16'h1234, 16'h0000, 1'b0, 1'b0, 16'h0000};
    steps[19] = '{REQ_LOAD_REV, 9'd256, 16'hABCD, 16'h4321, 1'b0, 1'b0, 16'h0000};
    steps[20] = '{REQ_LOAD_REV, 9'd1,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000};
    steps[21] = '{REQ_LOOK_REV, 9'd0,   16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000};

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_EMPTY_ROWS) begin
        settle();
        write_settings(16'd3, 16'd1, 16'h0000, 16'hA5A5);
      end
      issue_request(steps[i].req, steps[i].slot, steps[i].key, steps[i].val,
                    steps[i].typed, steps[i].hit, steps[i].ans);
    end

    run_phase(16'd1, 16'd2, 16'($urandom), 16'($urandom), 60, 1'b1);
    // full depth on the forward side; its count drops the upper bits, then saturates
    run_phase(16'h0301, 16'd5, 16'h0000, 16'hFFFF, 80, 1'b1);
    run_phase(16'd0, 16'($urandom_range(1, 31)), 16'($urandom), 16'($urandom),
              50, 1'b1);
    run_phase(16'($urandom_range(1, 31)), 16'($urandom_range(1, 31)),
              16'($urandom), 16'($urandom), 60, 1'b1);
    run_phase(16'($urandom_range(1, 48)), 16'($urandom_range(1, 48)),
              16'($urandom), 16'($urandom), 60, 1'b1);
    run_phase(16'($urandom_range(1, 24)), 16'($urandom_range(1, 24)),
              16'($urandom), 16'($urandom), 60, 1'b0);
    settle();

    $display("summary: %0d lookups (%0d hits), %0d loads, %0d sets of settings",
             lookups_sent, hits_due, loads_sent, settings_written);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
